FILE: rtl/pic_pkg.sv
package pic_pkg;

  localparam int MAX_DIMS_DEF  = 8;
  localparam int MAX_FACES_DEF = 64;

  localparam int FACE_SEL_W  = 6;
  localparam int ELEM_IDX_W  = 4;
  localparam int VALUE_W     = 32;
  localparam int PNUM_W      = 32;
  localparam int FCOUNT_W    = 7;
  localparam int DIMS_W      = 4;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_FACE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS       = 1'b1;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_POINT = 1'b1;

  localparam logic [DIMS_W-1:0] DIMS_RESET = 4'd3;

  // Q16.16 offset scaled to Q32.32 through the shared multiplier
  localparam logic signed [VALUE_W-1:0] OFFSET_SCALE = 32'sd65536;

  typedef struct packed {
    logic load_we;
    logic coord_we;
    logic clear_base;
    logic adv_base;
    logic issue;
    logic is_offset;
    logic first;
    logic last;
    logic load_out;
    logic in_hull;
  } cmd_t;

  typedef struct packed {
    logic face_done;
    logic face_pos;
  } sts_t;

endpackage

FILE: rtl/pic_ctrl.sv
module pic_ctrl #(
  parameter int MAX_DIMS  = pic_pkg::MAX_DIMS_DEF,
  parameter int MAX_FACES = pic_pkg::MAX_FACES_DEF,
  parameter int SW        = $clog2(MAX_DIMS + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_req,
  input  logic                           in_last,
  output logic                           in_tready,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_valid,
  input  logic [pic_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pic_pkg::CFG_DATA_W-1:0] cfg_data,
  output pic_pkg::cmd_t                  cmd,
  output logic [SW-1:0]                  cmd_slot,
  input  pic_pkg::sts_t                  sts
);

  localparam int FW  = $clog2(MAX_FACES + 1);
  localparam int CW  = (FW > pic_pkg::FCOUNT_W) ? FW : pic_pkg::FCOUNT_W;
  localparam int DCW = (SW > pic_pkg::DIMS_W) ? SW : pic_pkg::DIMS_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ISSUE  = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0]                        state_r, state_nxt;
  logic [SW-1:0]                     slot_r, slot_nxt;
  logic [CW-1:0]                     fc_r, fc_nxt;
  logic                              inside_r, inside_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [pic_pkg::FCOUNT_W-1:0]      face_count_r, face_count_nxt;
  logic [pic_pkg::DIMS_W-1:0]        dims_r, dims_nxt;
  logic [SW-1:0]                     d_eff;
  logic [CW-1:0]                     nf;
  logic                              accept;

  always_comb begin
    if (dims_r == '0) begin
      d_eff = SW'(1);
    end else if (DCW'(dims_r) > DCW'(MAX_DIMS)) begin
      d_eff = SW'(MAX_DIMS);
    end else begin
      d_eff = SW'(dims_r);
    end
    if (CW'(face_count_r) > CW'(MAX_FACES)) begin
      nf = CW'(MAX_FACES);
    end else begin
      nf = CW'(face_count_r);
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign accept     = in_tvalid && in_tready;
  assign cmd_slot   = slot_r;

  always_comb begin
    state_nxt      = state_r;
    slot_nxt       = slot_r;
    fc_nxt         = fc_r;
    inside_nxt     = inside_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    face_count_nxt = face_count_r;
    dims_nxt       = dims_r;

    cmd            = '0;
    cmd.load_we    = accept && (in_req == pic_pkg::REQ_LOAD);
    cmd.coord_we   = accept && (in_req == pic_pkg::REQ_POINT);
    cmd.is_offset  = (slot_r == d_eff);
    cmd.first      = (slot_r == '0);
    cmd.last       = (slot_r == d_eff);
    cmd.in_hull    = inside_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_req == pic_pkg::REQ_POINT) && in_last) begin
          if (nf == '0) begin
            inside_nxt = 1'b1;
            state_nxt  = ST_RESULT;
          end else begin
            cmd.clear_base = 1'b1;
            slot_nxt       = '0;
            fc_nxt         = '0;
            state_nxt      = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (slot_r == d_eff) begin
          slot_nxt  = '0;
          state_nxt = ST_WAIT;
        end else begin
          slot_nxt = slot_r + SW'(1);
        end
      end
      ST_WAIT: begin
        if (sts.face_done) begin
          if (sts.face_pos) begin
            inside_nxt = 1'b0;
            state_nxt  = ST_RESULT;
          end else if (fc_r + CW'(1) == nf) begin
            inside_nxt = 1'b1;
            state_nxt  = ST_RESULT;
          end else begin
            fc_nxt       = fc_r + CW'(1);
            cmd.adv_base = 1'b1;
            state_nxt    = ST_ISSUE;
          end
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
    endcase

    if (cfg_valid) begin
      unique case (cfg_index)
        pic_pkg::CFG_FACE_COUNT: face_count_nxt = cfg_data;
        pic_pkg::CFG_DIMS:       dims_nxt       = cfg_data[pic_pkg::DIMS_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slot_r       <= '0;
      fc_r         <= '0;
      inside_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      face_count_r <= '0;
      dims_r       <= pic_pkg::DIMS_RESET;
    end else begin
      state_r      <= state_nxt;
      slot_r       <= slot_nxt;
      fc_r         <= fc_nxt;
      inside_r     <= inside_nxt;
      out_valid_r  <= out_valid_nxt;
      face_count_r <= face_count_nxt;
      dims_r       <= dims_nxt;
    end
  end

endmodule

FILE: rtl/pic_dp.sv
module pic_dp #(
  parameter int MAX_DIMS  = pic_pkg::MAX_DIMS_DEF,
  parameter int MAX_FACES = pic_pkg::MAX_FACES_DEF,
  parameter int SW        = $clog2(MAX_DIMS + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [pic_pkg::FACE_SEL_W-1:0]  face_sel,
  input  logic [pic_pkg::ELEM_IDX_W-1:0]  elem_index,
  input  logic [pic_pkg::VALUE_W-1:0]     value,
  input  pic_pkg::cmd_t                   cmd,
  input  logic [SW-1:0]                   cmd_slot,
  output pic_pkg::sts_t                   sts,
  output logic                            out_inside,
  output logic [pic_pkg::PNUM_W-1:0]      out_num
);

  localparam int STRIDE = MAX_DIMS + 1;
  localparam int DEPTH  = MAX_FACES * STRIDE;
  localparam int AW     = $clog2(DEPTH);
  localparam int PW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int WAW    = (AW > 12) ? AW : 12;
  localparam int ACC_W  = 2 * pic_pkg::VALUE_W + $clog2(MAX_DIMS + 1);
  localparam int FSW    = 11;
  localparam int ESW    = 5;

  logic [pic_pkg::VALUE_W-1:0]        mem [DEPTH];
  logic [pic_pkg::VALUE_W-1:0]        pbuf_r [MAX_DIMS];

  logic [AW-1:0]                      base_r;
  logic [AW-1:0]                      rd_addr;
  logic [WAW-1:0]                     wr_wide;
  logic                               load_ok;
  logic                               coord_ok;

  logic signed [pic_pkg::VALUE_W-1:0] rd_data_r;
  logic signed [pic_pkg::VALUE_W-1:0] b1_r;
  logic                               v1_r, first1_r, last1_r;
  logic signed [2*pic_pkg::VALUE_W-1:0] prod_r;
  logic                               v2_r, first2_r, last2_r;
  logic signed [ACC_W-1:0]            acc_r, acc_nxt;
  logic                               done_r;
  logic [pic_pkg::PNUM_W-1:0]         pcnt_r;
  logic                               out_inside_r;
  logic [pic_pkg::PNUM_W-1:0]         out_num_r;

  assign wr_wide  = WAW'(face_sel) * WAW'(STRIDE) + WAW'(elem_index);
  assign load_ok  = (FSW'(face_sel) < FSW'(MAX_FACES)) && (ESW'(elem_index) <= ESW'(MAX_DIMS));
  assign coord_ok = (ESW'(elem_index) < ESW'(MAX_DIMS));
  assign rd_addr  = base_r + AW'(cmd_slot);

  always_ff @(posedge clk) begin
    if (cmd.load_we && load_ok) begin
      mem[wr_wide[AW-1:0]] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.coord_we && coord_ok) begin
      pbuf_r[elem_index[PW-1:0]] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_base) begin
      base_r <= '0;
    end else if (cmd.adv_base) begin
      base_r <= base_r + AW'(STRIDE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      b1_r     <= cmd.is_offset ? pic_pkg::OFFSET_SCALE : pbuf_r[cmd_slot[PW-1:0]];
      first1_r <= cmd.first;
      last1_r  <= cmd.last;
    end
    if (v1_r) begin
      prod_r   <= rd_data_r * b1_r;
      first2_r <= first1_r;
      last2_r  <= last1_r;
    end
    if (v2_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc_nxt = (first2_r ? ACC_W'(0) : acc_r) + ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= cmd.issue;
      v2_r   <= v1_r;
      done_r <= v2_r && last2_r;
    end
  end

  assign sts.face_done = done_r;
  assign sts.face_pos  = !acc_r[ACC_W-1] && (acc_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r <= '0;
    end else if (cmd.load_out) begin
      pcnt_r <= pcnt_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_inside_r <= cmd.in_hull;
      out_num_r    <= pcnt_r;
    end
  end

  assign out_inside = out_inside_r;
  assign out_num    = out_num_r;

endmodule

FILE: rtl/point_in_convex_polytope.sv
// A new load or coordinate item is taken only while idle. A point marked last is tested
// face by face through the single shared multiply-accumulate (table read, multiply,
// accumulate); walking stops at an outside face.
// Reset clears control, the point counter, face_count to 0 and dims to 3. The face table and
// point buffer are not cleared and take no clearing pass.
module point_in_convex_polytope #(
  parameter int MAX_DIMS  = pic_pkg::MAX_DIMS_DEF,
  parameter int MAX_FACES = pic_pkg::MAX_FACES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [pic_pkg::IN_TDATA_W-1:0]  in_tdata,   // face_sel, elem_index, value
  input  logic                            in_tuser,   // req_type
  input  logic                            in_tlast,   // last_coord
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [pic_pkg::OUT_TDATA_W-1:0] out_tdata,  // inside_res, point_number
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pic_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pic_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SW = $clog2(MAX_DIMS + 1);

  pic_pkg::cmd_t               cmd;
  pic_pkg::sts_t               sts;
  logic [SW-1:0]               cmd_slot;
  logic                        out_inside;
  logic [pic_pkg::PNUM_W-1:0]  out_num;

  assign cfg_ready = 1'b1;

  pic_ctrl #(
    .MAX_DIMS  (MAX_DIMS),
    .MAX_FACES (MAX_FACES),
    .SW        (SW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_req     (in_tuser),
    .in_last    (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .cmd_slot   (cmd_slot),
    .sts        (sts)
  );

  pic_dp #(
    .MAX_DIMS  (MAX_DIMS),
    .MAX_FACES (MAX_FACES),
    .SW        (SW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .face_sel   (in_tdata[5:0]),
    .elem_index (in_tdata[9:6]),
    .value      (in_tdata[41:10]),
    .cmd        (cmd),
    .cmd_slot   (cmd_slot),
    .sts        (sts),
    .out_inside (out_inside),
    .out_num    (out_num)
  );

  assign out_tdata = {7'b0, out_num, out_inside};

  a_issue_busy : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> !in_tready)
    else $error("face read issued while accepting items");

  a_done_busy : assert property (@(posedge clk) disable iff (!rst_n)
    sts.face_done |-> !in_tready)
    else $error("face sum completed outside a test");

  a_load_out : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_tvalid && (out_tdata[0] == $past(cmd.in_hull)))
    else $error("result register not loaded");

endmodule
